FILE: src/gqtb_pkg.sv
// -----------------------------------------------------------------------------
// gqtb_pkg
// Shared widths, codes, queue word type and helpers of the glyph quad builder.
// -----------------------------------------------------------------------------
package gqtb_pkg;

  localparam int POS_W     = 20;
  localparam int DEPTH_W   = 16;
  localparam int COLOR_W   = 32;
  localparam int SCALE_W   = 12;
  localparam int NUM_W     = 32;
  localparam int CODE_W    = 9;
  localparam int BOX_W     = 64;
  localparam int ADV_W     = 16;
  localparam int UV_W      = 64;
  localparam int OFF_W     = 16;
  localparam int TEX_W     = 16;
  localparam int OPCODE_W  = 2;
  localparam int FSEL_W    = 2;
  localparam int CORNER_W  = 3;

  localparam int DEF_GLYPHS_PER_SIZE = 96;
  localparam int DEF_FONT_SIZES      = 4;
  localparam int CHAR_BASE           = 32;

  localparam int POS_MAX = 524287;
  localparam int POS_MIN = -524288;

  // store entry: {uv, advance, box}
  localparam int ENT_W = UV_W + ADV_W + BOX_W;

  // offset (16 b signed) times scale (13 b signed, positive)
  localparam int PROD_W = OFF_W + SCALE_W + 1;
  // product after rounding to Q.4
  localparam int SCL_W  = PROD_W - 3;
  // working width for sums ahead of saturation
  localparam int SUM_W  = PROD_W + 1;

  localparam int QUEUE_DEPTH  = 2;
  localparam int NUM_RESULTS  = 10;
  localparam int NUM_CORNERS  = 4;
  localparam int CNT_W        = 4;

  localparam logic [OPCODE_W-1:0] OP_START = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DRAW  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd2;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_INDEX  = 1'b1;

  localparam logic [CORNER_W-1:0] LAST_SLOT = 3'd5;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [SCL_W-1:0] scl_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // one finished quad, as handed from the front to the back
  typedef struct packed {
    pos_t                      ax;
    pos_t                      ay;
    pos_t                      cx;
    pos_t                      cy;
    logic signed [DEPTH_W-1:0] z;
    logic [TEX_W-1:0]          u0;
    logic [TEX_W-1:0]          v0;
    logic [TEX_W-1:0]          u1;
    logic [TEX_W-1:0]          v1;
    logic [COLOR_W-1:0]        color;
    logic [NUM_W-1:0]          base;
  } quad_t;

  function automatic pos_t sat_pos(input sum_t v);
    pos_t r;
    if (v > sum_t'(POS_MAX)) begin
      r = pos_t'(POS_MAX);
    end else if (v < sum_t'(POS_MIN)) begin
      r = pos_t'(POS_MIN);
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  // corner used by each of the six index slots
  function automatic logic [1:0] slot_corner(input logic [CORNER_W-1:0] slot);
    logic [1:0] r;
    case (slot)
      3'd0:    r = 2'd0;
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd2;
      3'd3:    r = 2'd0;
      3'd4:    r = 2'd2;
      3'd5:    r = 2'd3;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: src/gqtb_in_if.sv
// -----------------------------------------------------------------------------
// gqtb_in_if
// Input word channel: start, draw and load items.
// -----------------------------------------------------------------------------
interface gqtb_in_if import gqtb_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic signed [POS_W-1:0]    pen_x;
  logic signed [POS_W-1:0]    pen_y;
  logic signed [DEPTH_W-1:0]  depth_z;
  logic [COLOR_W-1:0]         draw_color;
  logic [SCALE_W-1:0]         scale;
  logic [NUM_W-1:0]           base_vertex;
  logic [CODE_W-1:0]          code_or_slot;
  logic [BOX_W-1:0]           glyph_box;
  logic signed [ADV_W-1:0]    glyph_advance;
  logic [UV_W-1:0]            glyph_uv;

  modport source (
    output valid, opcode, pen_x, pen_y, depth_z, draw_color, scale, base_vertex,
           code_or_slot, glyph_box, glyph_advance, glyph_uv,
    input  ready
  );
  modport sink (
    input  valid, opcode, pen_x, pen_y, depth_z, draw_color, scale, base_vertex,
           code_or_slot, glyph_box, glyph_advance, glyph_uv,
    output ready
  );
endinterface

FILE: src/gqtb_out_if.sv
// -----------------------------------------------------------------------------
// gqtb_out_if
// Result word channel: vertex and index records.
// -----------------------------------------------------------------------------
interface gqtb_out_if import gqtb_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [CORNER_W-1:0]        corner;
  logic signed [POS_W-1:0]    out_x;
  logic signed [POS_W-1:0]    out_y;
  logic signed [DEPTH_W-1:0]  out_z;
  logic [TEX_W-1:0]           tex_u;
  logic [TEX_W-1:0]           tex_v;
  logic [COLOR_W-1:0]         out_color;
  logic [NUM_W-1:0]           element_number;
  logic                       last;

  modport source (
    output valid, kind, corner, out_x, out_y, out_z, tex_u, tex_v, out_color,
           element_number, last,
    input  ready
  );
  modport sink (
    input  valid, kind, corner, out_x, out_y, out_z, tex_u, tex_v, out_color,
           element_number, last,
    output ready
  );
endinterface

FILE: src/gqtb_cfg_if.sv
// -----------------------------------------------------------------------------
// gqtb_cfg_if
// Configuration write channel carrying the font size select.
// -----------------------------------------------------------------------------
interface gqtb_cfg_if import gqtb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FSEL_W-1:0] font_select;

  modport source (output valid, font_select, input ready);
  modport sink   (input valid, font_select, output ready);
endinterface

FILE: src/gqtb_front.sv
// -----------------------------------------------------------------------------
// gqtb_front
// Accepts words, keeps string state and the glyph store, builds quad geometry.
// -----------------------------------------------------------------------------
module gqtb_front import gqtb_pkg::*; #(
  parameter int GLYPHS_PER_SIZE = DEF_GLYPHS_PER_SIZE,
  parameter int FONT_SIZES      = DEF_FONT_SIZES
) (
  input  logic          clk,
  input  logic          rst_n,
  gqtb_in_if.sink       in_ch,
  gqtb_cfg_if.sink      cfg_ch,
  input  logic          q_full,
  output logic          q_push,
  output quad_t         q_data
);

  localparam int STORE_DEPTH = FONT_SIZES * GLYPHS_PER_SIZE;
  localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic [ENT_W-1:0] mem [STORE_DEPTH];

  logic [FSEL_W-1:0]          font_select_r;
  pos_t                       pen_x_r;
  pos_t                       pen_y_r;
  logic signed [DEPTH_W-1:0]  depth_r;
  logic [COLOR_W-1:0]         color_r;
  logic [SCALE_W-1:0]         scale_r;
  logic [NUM_W-1:0]           next_vertex_r;

  logic vld_b_r, vld_c_r, vld_d_r;
  logic busy;
  logic accept, is_draw, is_load, is_start;

  logic [31:0]       code_ext, glyph_g, fsel_mod, idx_ext;
  logic [IDX_W-1:0]  rd_idx, wr_idx;
  logic              wr_ok;

  // stage B: store data present
  logic [ENT_W-1:0]   rd_data_r;
  logic [NUM_W-1:0]   base_b_r;
  logic signed [OFF_W-1:0] bx0, by0, bx1, by1;
  logic signed [ADV_W-1:0] adv;
  logic signed [SCALE_W:0] scale_s;
  prod_t py0_nxt, px1_nxt, py1_nxt, padv_nxt;
  pos_t  ax_nxt;

  // stage C: products present
  prod_t              py0_c_r, px1_c_r, py1_c_r, padv_c_r;
  pos_t               ax_c_r;
  logic [UV_W-1:0]    uv_c_r;
  logic [NUM_W-1:0]   base_c_r;
  scl_t               sy0, sx1, sy1, sadv;
  pos_t               ay_nxt, pen_x_nxt;

  // stage D: corner origins present
  pos_t               ax_d_r, ay_d_r;
  scl_t               sx1_d_r, sy1_d_r;
  logic [UV_W-1:0]    uv_d_r;
  logic [NUM_W-1:0]   base_d_r;

  assign cfg_ch.ready = 1'b1;

  // one draw in flight at a time: the next draw needs the advanced pen
  assign busy        = vld_b_r | vld_c_r | vld_d_r;
  assign in_ch.ready = ~busy & ~q_full;
  assign accept      = in_ch.valid & in_ch.ready;
  assign is_start    = accept & (in_ch.opcode == OP_START);
  assign is_draw     = accept & (in_ch.opcode == OP_DRAW);
  assign is_load     = accept & (in_ch.opcode == OP_LOAD);

  // glyph lookup address
  always_comb begin
    code_ext = 32'(in_ch.code_or_slot);
    if ((code_ext < 32'(CHAR_BASE)) ||
        ((code_ext - 32'(CHAR_BASE)) >= 32'(GLYPHS_PER_SIZE))) begin
      glyph_g = 32'(GLYPHS_PER_SIZE - 1);
    end else begin
      glyph_g = code_ext - 32'(CHAR_BASE);
    end
    // fold the select into the table range by repeated subtraction
    fsel_mod = 32'(font_select_r);
    for (int i = 0; i < (1 << FSEL_W) - 1; i++) begin
      if (fsel_mod >= 32'(FONT_SIZES)) begin
        fsel_mod = fsel_mod - 32'(FONT_SIZES);
      end
    end
    idx_ext  = fsel_mod * 32'(GLYPHS_PER_SIZE) + glyph_g;
    rd_idx   = idx_ext[IDX_W-1:0];
    wr_idx   = code_ext[IDX_W-1:0];
    wr_ok    = code_ext < 32'(STORE_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (is_load && wr_ok) begin
      mem[wr_idx] <= {in_ch.glyph_uv, in_ch.glyph_advance, in_ch.glyph_box};
    end
    if (is_draw) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  // stage B: multiply offsets by scale, place corner 0 x
  always_comb begin
    bx0      = rd_data_r[15:0];
    by0      = rd_data_r[31:16];
    bx1      = rd_data_r[47:32];
    by1      = rd_data_r[63:48];
    adv      = rd_data_r[BOX_W +: ADV_W];
    scale_s  = $signed({1'b0, scale_r});
    py0_nxt  = prod_t'(by0) * prod_t'(scale_s);
    px1_nxt  = prod_t'(bx1) * prod_t'(scale_s);
    py1_nxt  = prod_t'(by1) * prod_t'(scale_s);
    padv_nxt = prod_t'(adv) * prod_t'(scale_s);
    ax_nxt   = sat_pos(sum_t'(pen_x_r) + sum_t'($signed({bx0, 4'h0})));
  end

  // stage C: round Q.8 to Q.4 (half up), place corner 0 y, advance pen
  always_comb begin
    sy0       = scl_t'((sum_t'(py0_c_r) + sum_t'(8)) >>> 4);
    sx1       = scl_t'((sum_t'(px1_c_r) + sum_t'(8)) >>> 4);
    sy1       = scl_t'((sum_t'(py1_c_r) + sum_t'(8)) >>> 4);
    sadv      = scl_t'((sum_t'(padv_c_r) + sum_t'(8)) >>> 4);
    ay_nxt    = sat_pos(sum_t'(pen_y_r) - sum_t'(sy0));
    pen_x_nxt = sat_pos(sum_t'(pen_x_r) + sum_t'(sadv));
  end

  // stage D: far corner, hand quad to queue
  always_comb begin
    q_push       = vld_d_r;
    q_data.ax    = ax_d_r;
    q_data.ay    = ay_d_r;
    q_data.cx    = sat_pos(sum_t'(ax_d_r) + sum_t'(sx1_d_r));
    q_data.cy    = sat_pos(sum_t'(ay_d_r) + sum_t'(sy1_d_r));
    q_data.z     = depth_r;
    q_data.u0    = uv_d_r[15:0];
    q_data.v0    = uv_d_r[31:16];
    q_data.u1    = uv_d_r[47:32];
    q_data.v1    = uv_d_r[63:48];
    q_data.color = color_r;
    q_data.base  = base_d_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      font_select_r <= '0;
      pen_x_r       <= '0;
      pen_y_r       <= '0;
      depth_r       <= '0;
      color_r       <= '0;
      scale_r       <= '0;
      next_vertex_r <= '0;
      vld_b_r       <= 1'b0;
      vld_c_r       <= 1'b0;
      vld_d_r       <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        font_select_r <= cfg_ch.font_select;
      end
      if (is_start) begin
        pen_x_r       <= in_ch.pen_x;
        pen_y_r       <= in_ch.pen_y;
        depth_r       <= in_ch.depth_z;
        color_r       <= in_ch.draw_color;
        scale_r       <= in_ch.scale;
        next_vertex_r <= in_ch.base_vertex;
      end else if (is_draw) begin
        next_vertex_r <= next_vertex_r + NUM_W'(NUM_CORNERS);
      end else if (vld_c_r) begin
        pen_x_r <= pen_x_nxt;
      end
      vld_b_r <= is_draw;
      vld_c_r <= vld_b_r;
      vld_d_r <= vld_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (is_draw) begin
      base_b_r <= next_vertex_r;
    end
    if (vld_b_r) begin
      py0_c_r  <= py0_nxt;
      px1_c_r  <= px1_nxt;
      py1_c_r  <= py1_nxt;
      padv_c_r <= padv_nxt;
      ax_c_r   <= ax_nxt;
      uv_c_r   <= rd_data_r[BOX_W + ADV_W +: UV_W];
      base_c_r <= base_b_r;
    end
    if (vld_c_r) begin
      ax_d_r   <= ax_c_r;
      ay_d_r   <= ay_nxt;
      sx1_d_r  <= sx1;
      sy1_d_r  <= sy1;
      uv_d_r   <= uv_c_r;
      base_d_r <= base_c_r;
    end
  end

endmodule

FILE: src/gqtb_queue.sv
// -----------------------------------------------------------------------------
// gqtb_queue
// Short FIFO of finished quads between the front and the back.
// -----------------------------------------------------------------------------
module gqtb_queue import gqtb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  quad_t push_data,
  input  logic  pop,
  output quad_t head,
  output logic  full,
  output logic  empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  quad_t              slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_QW-1:0]  count_r, count_nxt;
  logic               do_push, do_pop;

  assign full    = count_r == CNT_QW'(QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: src/gqtb_back.sv
// -----------------------------------------------------------------------------
// gqtb_back
// Four vertex and six index records per quad, one per cycle unless stalled.
// -----------------------------------------------------------------------------
module gqtb_back import gqtb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  quad_t      head,
  input  logic       empty,
  output logic       pop,
  gqtb_out_if.source out_ch
);

  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                out_valid_r;
  logic                load;
  logic                is_vert;
  logic [CORNER_W-1:0] slot;
  logic [1:0]          vcorner;

  logic                      kind_nxt, kind_r;
  logic [CORNER_W-1:0]       corner_nxt, corner_r;
  pos_t                      x_nxt, x_r, y_nxt, y_r;
  logic signed [DEPTH_W-1:0] z_nxt, z_r;
  logic [TEX_W-1:0]          u_nxt, u_r, v_nxt, v_r;
  logic [COLOR_W-1:0]        color_nxt, color_r;
  logic [NUM_W-1:0]          num_nxt, num_r;
  logic                      last_nxt, last_r;

  // with a quad waiting, refill the output register when empty or taken
  assign load = ~empty & (~out_valid_r | out_ch.ready);
  assign pop  = load & (cnt_r == CNT_W'(NUM_RESULTS - 1));

  always_comb begin
    is_vert = cnt_r < CNT_W'(NUM_CORNERS);
    slot    = is_vert ? cnt_r[CORNER_W-1:0] : CORNER_W'(cnt_r - CNT_W'(NUM_CORNERS));
    vcorner = is_vert ? cnt_r[1:0] : slot_corner(slot);
    cnt_nxt = pop ? '0 : cnt_r + 1'b1;

    kind_nxt   = is_vert ? KIND_VERTEX : KIND_INDEX;
    corner_nxt = slot;
    num_nxt    = head.base + NUM_W'(vcorner);
    last_nxt   = ~is_vert & (slot == LAST_SLOT);
    x_nxt      = '0;
    y_nxt      = '0;
    z_nxt      = '0;
    u_nxt      = '0;
    v_nxt      = '0;
    color_nxt  = '0;
    if (is_vert) begin
      // corners 0 and 3 sit on the left edge, 0 and 1 on the top edge
      x_nxt     = (vcorner == 2'd0 || vcorner == 2'd3) ? head.ax : head.cx;
      y_nxt     = (vcorner == 2'd0 || vcorner == 2'd1) ? head.ay : head.cy;
      u_nxt     = (vcorner == 2'd0 || vcorner == 2'd3) ? head.u0 : head.u1;
      v_nxt     = (vcorner == 2'd0 || vcorner == 2'd1) ? head.v0 : head.v1;
      z_nxt     = head.z;
      color_nxt = head.color;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r   <= kind_nxt;
      corner_r <= corner_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      z_r      <= z_nxt;
      u_r      <= u_nxt;
      v_r      <= v_nxt;
      color_r  <= color_nxt;
      num_r    <= num_nxt;
      last_r   <= last_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = kind_r;
  assign out_ch.corner         = corner_r;
  assign out_ch.out_x          = x_r;
  assign out_ch.out_y          = y_r;
  assign out_ch.out_z          = z_r;
  assign out_ch.tex_u          = u_r;
  assign out_ch.tex_v          = v_r;
  assign out_ch.out_color      = color_r;
  assign out_ch.element_number = num_r;
  assign out_ch.last           = last_r;

endmodule

FILE: src/glyph_quad_text_builder_unit.sv
// Draw word: records pass stages B, C, D, the queue and the output register, then
// leave one per cycle unless the output stalls, ten per character (four vertices,
// six indices); the output register sets that rate. The front takes no word while a
// draw is in stage B, C or D or the queue is full, else one start or load per cycle.
// Reset (rst_n, synchronous, active low) clears string state, font select and
// control; glyph store contents stay undefined until loaded, with no clearing pass.
// -----------------------------------------------------------------------------
// glyph_quad_text_builder_unit
// Bitmap font text to textured quads: front, quad queue and record emitter.
// -----------------------------------------------------------------------------
module glyph_quad_text_builder_unit import gqtb_pkg::*; #(
  parameter int GLYPHS_PER_SIZE = DEF_GLYPHS_PER_SIZE,
  parameter int FONT_SIZES      = DEF_FONT_SIZES
) (
  input  logic       clk,
  input  logic       rst_n,
  gqtb_in_if.sink    in_ch,
  gqtb_cfg_if.sink   cfg_ch,
  gqtb_out_if.source out_ch
);

  logic  q_push, q_pop, q_full, q_empty;
  quad_t q_data, q_head;

  gqtb_front #(
    .GLYPHS_PER_SIZE (GLYPHS_PER_SIZE),
    .FONT_SIZES      (FONT_SIZES)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data)
  );

  gqtb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  gqtb_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .empty  (q_empty),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

endmodule

FILE: src/gqtb_checker.sv
// -----------------------------------------------------------------------------
// gqtb_checker
// Port-level checks on the result word stream of the glyph quad builder.
// -----------------------------------------------------------------------------
module gqtb_checker import gqtb_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_kind,
  input logic [CORNER_W-1:0] out_corner,
  input logic [NUM_W-1:0]    out_number,
  input logic                out_last
);

  // hold a stalled word
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_number) && $stable(out_corner))
    else $error("stalled result word changed");

  // last marks only the final index slot
  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_kind == KIND_INDEX && out_corner == LAST_SLOT)
    else $error("last flag on wrong record");

  // vertex corners run in order with consecutive numbers
  a_vertex_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_kind == KIND_VERTEX && out_corner < 3'd3
    |=> !out_valid || (out_kind == KIND_VERTEX &&
                       out_corner == $past(out_corner) + 3'd1 &&
                       out_number == $past(out_number) + 32'd1))
    else $error("vertex corner sequence broken");

  // index records follow the fourth vertex
  a_index_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_kind == KIND_VERTEX && out_corner == 3'd3
    |=> !out_valid || (out_kind == KIND_INDEX && out_corner == 3'd0 &&
                       out_number == $past(out_number) - 32'd3))
    else $error("index records do not follow vertices");

  // drop valid out of reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind glyph_quad_text_builder_unit gqtb_checker u_gqtb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_kind   (out_ch.kind),
  .out_corner (out_ch.corner),
  .out_number (out_ch.element_number),
  .out_last   (out_ch.last)
);

FILE: test/glyph_quad_text_builder_unit_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// glyph_quad_text_builder_unit_tb
// Drives start, load and draw words into the glyph quad builder and predicts
// the four vertex and six index records of every drawn character. Each record
// that leaves the block is checked field by field against the oldest
// prediction. Both sides idle at random. The font select is changed between
// phases while the block is idle.
// -----------------------------------------------------------------------------
module glyph_quad_text_builder_unit_tb;
  import gqtb_pkg::*;

  localparam int GLYPHS        = DEF_GLYPHS_PER_SIZE;
  localparam int FONTS         = DEF_FONT_SIZES;
  localparam int STORE_SLOTS   = GLYPHS * FONTS;
  localparam int SLOT_TOP      = (1 << CODE_W) - 1;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 800000;
  localparam int PHASE_WORDS   = 81;

  localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;

  typedef struct {
    logic [OPCODE_W-1:0]       opcode;
    pos_t                      pen_x;
    pos_t                      pen_y;
    logic signed [DEPTH_W-1:0] depth_z;
    logic [COLOR_W-1:0]        draw_color;
    logic [SCALE_W-1:0]        scale;
    logic [NUM_W-1:0]          base_vertex;
    logic [CODE_W-1:0]         code_or_slot;
    logic [BOX_W-1:0]          glyph_box;
    logic signed [ADV_W-1:0]   glyph_advance;
    logic [UV_W-1:0]           glyph_uv;
  } text_word_t;

  typedef struct {
    logic                      kind;
    logic [CORNER_W-1:0]       corner;
    pos_t                      out_x;
    pos_t                      out_y;
    logic signed [DEPTH_W-1:0] out_z;
    logic [TEX_W-1:0]          tex_u;
    logic [TEX_W-1:0]          tex_v;
    logic [COLOR_W-1:0]        out_color;
    logic [NUM_W-1:0]          element_number;
    logic                      last;
  } quad_rec_t;

  // string state, glyph store and the records still owed by the block
  class quad_record_board;
    logic [FSEL_W-1:0]         font_sel;
    pos_t                      pen_x;
    pos_t                      pen_y;
    logic signed [DEPTH_W-1:0] pen_z;
    logic [COLOR_W-1:0]        color;
    logic [SCALE_W-1:0]        scale;
    logic [NUM_W-1:0]          next_vertex;
    logic [BOX_W-1:0]          box_mem [STORE_SLOTS];
    logic [UV_W-1:0]           uv_mem  [STORE_SLOTS];
    logic [ADV_W-1:0]          adv_mem [STORE_SLOTS];
    quad_rec_t                 expected_records [$];
    int                        mismatches;

    function new();
      font_sel    = '0;
      pen_x       = '0;
      pen_y       = '0;
      pen_z       = '0;
      color       = '0;
      scale       = '0;
      next_vertex = '0;
      mismatches  = 0;
    endfunction

    static function longint clamp_pos(longint v);
      if (v > POS_MAX) return POS_MAX;
      if (v < POS_MIN) return POS_MIN;
      return v;
    endfunction

    // integer offset times Q4.8 scale, rounded half up to Q.4
    static function longint round_scaled(longint off, logic [SCALE_W-1:0] sc);
      return (off * longint'(sc) + 8) >>> 4;
    endfunction

    function void push_record(logic kind, int corner, longint x, longint y,
                              logic signed [DEPTH_W-1:0] z, logic [TEX_W-1:0] u,
                              logic [TEX_W-1:0] v, logic [COLOR_W-1:0] col,
                              logic [NUM_W-1:0] num, logic last);
      quad_rec_t r;
      r.kind           = kind;
      r.corner         = corner[CORNER_W-1:0];
      r.out_x          = pos_t'(x);
      r.out_y          = pos_t'(y);
      r.out_z          = z;
      r.tex_u          = u;
      r.tex_v          = v;
      r.out_color      = col;
      r.element_number = num;
      r.last           = last;
      expected_records.push_back(r);
    endfunction

    function void build_quad(logic [CODE_W-1:0] code);
      int unsigned glyph;
      int unsigned slot;
      longint bx0, by0, bx1, by1, ax, ay, cx, cy;
      logic [BOX_W-1:0] box;
      logic [UV_W-1:0] uv;
      logic [NUM_W-1:0] base;
      int unsigned slot_map [6];
      slot_map = '{0, 1, 2, 0, 2, 3};
      if (code < CHAR_BASE || code - CHAR_BASE >= GLYPHS) begin
        glyph = GLYPHS - 1;
      end else begin
        glyph = code - CHAR_BASE;
      end
      slot = (font_sel % FONTS) * GLYPHS + glyph;
      box  = box_mem[slot];
      uv   = uv_mem[slot];
      bx0  = longint'($signed(box[15:0]));
      by0  = longint'($signed(box[31:16]));
      bx1  = longint'($signed(box[47:32]));
      by1  = longint'($signed(box[63:48]));
      // the left edge offset goes in unscaled
      ax   = clamp_pos(longint'(pen_x) + bx0 * 16);
      ay   = clamp_pos(longint'(pen_y) - round_scaled(by0, scale));
      cx   = clamp_pos(ax + round_scaled(bx1, scale));
      cy   = clamp_pos(ay + round_scaled(by1, scale));
      base = next_vertex;
      push_record(KIND_VERTEX, 0, ax, ay, pen_z, uv[15:0], uv[31:16], color, base, 1'b0);
      push_record(KIND_VERTEX, 1, cx, ay, pen_z, uv[47:32], uv[31:16], color, base + 1,
                  1'b0);
      push_record(KIND_VERTEX, 2, cx, cy, pen_z, uv[47:32], uv[63:48], color, base + 2,
                  1'b0);
      push_record(KIND_VERTEX, 3, ax, cy, pen_z, uv[15:0], uv[63:48], color, base + 3,
                  1'b0);
      for (int k = 0; k < 6; k++) begin
        push_record(KIND_INDEX, k, 0, 0, '0, '0, '0, '0, base + slot_map[k],
                    k == int'(LAST_SLOT));
      end
      next_vertex = base + 4;
      pen_x = pos_t'(clamp_pos(longint'(pen_x) +
                               round_scaled(longint'($signed(adv_mem[slot])), scale)));
    endfunction

    function void take_word(text_word_t w);
      case (w.opcode)
        OP_START: begin
          pen_x       = w.pen_x;
          pen_y       = w.pen_y;
          pen_z       = w.depth_z;
          color       = w.draw_color;
          scale       = w.scale;
          next_vertex = w.base_vertex;
        end
        OP_LOAD: begin
          if (w.code_or_slot < STORE_SLOTS) begin
            box_mem[w.code_or_slot] = w.glyph_box;
            uv_mem[w.code_or_slot]  = w.glyph_uv;
            adv_mem[w.code_or_slot] = w.glyph_advance;
          end
        end
        OP_DRAW: build_quad(w.code_or_slot);
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_record(quad_rec_t got);
      quad_rec_t want;
      if (expected_records.size() == 0) begin
        $error("record with nothing expected: kind %0d element_number %0h",
               got.kind, got.element_number);
        mismatches++;
        return;
      end
      want = expected_records.pop_front();
      compare_field("kind", 64'(want.kind), 64'(got.kind));
      compare_field("corner", 64'(want.corner), 64'(got.corner));
      compare_field("out_x", 64'(want.out_x), 64'(got.out_x));
      compare_field("out_y", 64'(want.out_y), 64'(got.out_y));
      compare_field("out_z", 64'(want.out_z), 64'(got.out_z));
      compare_field("tex_u", 64'(want.tex_u), 64'(got.tex_u));
      compare_field("tex_v", 64'(want.tex_v), 64'(got.tex_v));
      compare_field("out_color", 64'(want.out_color), 64'(got.out_color));
      compare_field("element_number", 64'(want.element_number),
                    64'(got.element_number));
      compare_field("last", 64'(want.last), 64'(got.last));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  gqtb_in_if  in_ch ();
  gqtb_cfg_if cfg_ch ();
  gqtb_out_if out_ch ();

  glyph_quad_text_builder_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  quad_record_board  board;
  bit                loaded [STORE_SLOTS];
  logic [FSEL_W-1:0] cur_font = '0;
  bit                src_steady = 1'b0;
  bit                sink_steady = 1'b0;
  int                sink_hold = 0;
  int                cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] pack_quad16(int a, int b, int c, int d);
    return {d[15:0], c[15:0], b[15:0], a[15:0]};
  endfunction

  // every field random, so that ignored fields carry noise
  function automatic text_word_t noise_word();
    text_word_t w;
    w.opcode        = OPCODE_W'($urandom);
    w.pen_x         = pos_t'($urandom);
    w.pen_y         = pos_t'($urandom);
    w.depth_z       = DEPTH_W'($urandom);
    w.draw_color    = $urandom;
    w.scale         = SCALE_W'($urandom);
    w.base_vertex   = $urandom;
    w.code_or_slot  = CODE_W'($urandom);
    w.glyph_box     = {$urandom, $urandom};
    w.glyph_advance = ADV_W'($urandom);
    w.glyph_uv      = {$urandom, $urandom};
    return w;
  endfunction

  function automatic text_word_t start_word(int px, int py, int z, logic [31:0] col,
                                            int sc, logic [31:0] base);
    text_word_t w;
    w             = noise_word();
    w.opcode      = OP_START;
    w.pen_x       = pos_t'(px);
    w.pen_y       = pos_t'(py);
    w.depth_z     = z[DEPTH_W-1:0];
    w.draw_color  = col;
    w.scale       = sc[SCALE_W-1:0];
    w.base_vertex = base;
    return w;
  endfunction

  function automatic text_word_t load_word(int slot, logic [63:0] box, int adv,
                                           logic [63:0] uv);
    text_word_t w;
    w               = noise_word();
    w.opcode        = OP_LOAD;
    w.code_or_slot  = slot[CODE_W-1:0];
    w.glyph_box     = box;
    w.glyph_advance = adv[ADV_W-1:0];
    w.glyph_uv      = uv;
    if (slot < STORE_SLOTS) loaded[slot] = 1'b1;
    return w;
  endfunction

  function automatic text_word_t draw_word(int code);
    text_word_t w;
    w              = noise_word();
    w.opcode       = OP_DRAW;
    w.code_or_slot = code[CODE_W-1:0];
    return w;
  endfunction

  function automatic text_word_t random_load();
    int r;
    int slot;
    logic [63:0] box;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      slot = cur_font * GLYPHS + $urandom_range(0, GLYPHS - 1);
    end else if (r < 95) begin
      slot = $urandom_range(0, STORE_SLOTS - 1);
    end else begin
      slot = $urandom_range(STORE_SLOTS, SLOT_TOP);
    end
    if ($urandom_range(0, 4) < 2) begin
      box = {$urandom, $urandom};
    end else begin
      box = pack_quad16($urandom_range(0, 200) - 100, $urandom_range(0, 200) - 100,
                        $urandom_range(0, 200) - 100, $urandom_range(0, 200) - 100);
    end
    return load_word(slot, box,
                     $urandom_range(0, 1) ? int'($urandom) : $urandom_range(0, 60) - 20,
                     {$urandom, $urandom});
  endfunction

  // draw only glyphs already loaded in the selected size table
  function automatic bit pick_draw(output text_word_t w);
    int unsigned ready_glyphs [$];
    int unsigned g;
    int code;
    for (int i = 0; i < GLYPHS; i++) begin
      if (loaded[cur_font * GLYPHS + i]) ready_glyphs.push_back(i);
    end
    if (ready_glyphs.size() == 0) return 1'b0;
    g = ready_glyphs[$urandom_range(0, ready_glyphs.size() - 1)];
    code = g + CHAR_BASE;
    // the last glyph is also reached by codes outside the table
    if (g == GLYPHS - 1 && $urandom_range(0, 3) != 0) begin
      code = $urandom_range(0, 1) ? $urandom_range(0, CHAR_BASE - 1)
                                  : $urandom_range(CHAR_BASE + GLYPHS, SLOT_TOP);
    end
    w = draw_word(code);
    return 1'b1;
  endfunction

  task automatic send_word(text_word_t w);
    int gap;
    gap = src_steady ? 0 : pick_idle();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= w.opcode;
    in_ch.pen_x         <= w.pen_x;
    in_ch.pen_y         <= w.pen_y;
    in_ch.depth_z       <= w.depth_z;
    in_ch.draw_color    <= w.draw_color;
    in_ch.scale         <= w.scale;
    in_ch.base_vertex   <= w.base_vertex;
    in_ch.code_or_slot  <= w.code_or_slot;
    in_ch.glyph_box     <= w.glyph_box;
    in_ch.glyph_advance <= w.glyph_advance;
    in_ch.glyph_uv      <= w.glyph_uv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic write_font(logic [FSEL_W-1:0] fs);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.font_select <= fs;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    cur_font = fs;
  endtask

  // hold the input until every owed record is out and the front has gone quiet
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.expected_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed();
    text_word_t w;
    send_word(load_word(0, pack_quad16(-3, 10, 7, 12), 9,
                        pack_quad16('h10, 'h20, 'h30, 'h40)));
    send_word(load_word(1, pack_quad16(32767, 32767, 32767, 32767), -32768, '0));
    send_word(load_word(GLYPHS - 1, pack_quad16(-32768, 32767, 32767, -32768), 32767,
                        '1));
    send_word(load_word(2, pack_quad16(5, -8, 8, -24), 8, {$urandom, $urandom}));
    // draw before any start runs on the reset string state
    send_word(draw_word(CHAR_BASE + 1));
    w = noise_word();
    w.opcode = OP_SPARE;
    send_word(w);
    send_word(start_word(POS_MAX, POS_MIN, -32768, 32'hFFFF_FFFF, 4095, 32'hFFFF_FFFE));
    send_word(draw_word(CHAR_BASE + 1));
    send_word(draw_word(0));
    send_word(draw_word(SLOT_TOP));
    send_word(draw_word(CHAR_BASE + GLYPHS - 1));
    send_word(draw_word(CHAR_BASE + GLYPHS));
    send_word(load_word(SLOT_TOP, {$urandom, $urandom}, 1, {$urandom, $urandom}));
    send_word(load_word(STORE_SLOTS, {$urandom, $urandom}, 1, {$urandom, $urandom}));
    send_word(load_word(STORE_SLOTS - 1, {$urandom, $urandom}, $urandom,
                        {$urandom, $urandom}));
    send_word(start_word(POS_MIN, POS_MAX, 32767, '0, 0, '0));
    send_word(draw_word(CHAR_BASE));
    send_word(draw_word(CHAR_BASE + 1));
    // scale of 1/256 (Q4.8 value 1) exposes the half-up rounding
    send_word(start_word(0, 0, 0, 32'h1122_3344, 1, 100));
    send_word(draw_word(CHAR_BASE + 2));
    send_word(draw_word(CHAR_BASE + 2));
    send_word(start_word(-1000, 2000, -5, 32'h8000_0001, 256, 32'h7FFF_FFFF));
    send_word(draw_word(CHAR_BASE));
    send_word(draw_word(CHAR_BASE + 2));
  endtask

  task automatic run_random(int target);
    int done;
    int pick;
    int px, py, sc;
    logic [31:0] base;
    bit counts;
    text_word_t w;
    done = 0;
    while (done < target) begin
      pick = $urandom_range(0, 99);
      counts = 1'b1;
      if (pick < 8) begin
        px = $urandom_range(0, 1) ? int'($urandom) : $urandom_range(0, 8000) - 4000;
        py = $urandom_range(0, 1) ? int'($urandom) : $urandom_range(0, 8000) - 4000;
        case ($urandom_range(0, 4))
          0, 1:    sc = $urandom_range(0, 4095);
          2, 3:    sc = $urandom_range(128, 512);
          default: sc = $urandom_range(0, 16);
        endcase
        base = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFF0 + $urandom_range(0, 15)
                                           : $urandom;
        w = start_word(px, py, $urandom, $urandom, sc, base);
      end else if (pick < 30 || !pick_draw(w)) begin
        w = random_load();
        counts = w.code_or_slot < STORE_SLOTS;
      end else if (pick < 33) begin
        w = noise_word();
        w.opcode = OP_SPARE;
        counts = 1'b0;
      end
      send_word(w);
      if (counts) done++;
    end
  endtask

  always @(posedge clk) begin : monitor
    text_word_t seen;
    quad_rec_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        seen.opcode        = in_ch.opcode;
        seen.pen_x         = in_ch.pen_x;
        seen.pen_y         = in_ch.pen_y;
        seen.depth_z       = in_ch.depth_z;
        seen.draw_color    = in_ch.draw_color;
        seen.scale         = in_ch.scale;
        seen.base_vertex   = in_ch.base_vertex;
        seen.code_or_slot  = in_ch.code_or_slot;
        seen.glyph_box     = in_ch.glyph_box;
        seen.glyph_advance = in_ch.glyph_advance;
        seen.glyph_uv      = in_ch.glyph_uv;
        board.take_word(seen);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        board.font_sel = cfg_ch.font_select;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.kind           = out_ch.kind;
        got.corner         = out_ch.corner;
        got.out_x          = out_ch.out_x;
        got.out_y          = out_ch.out_y;
        got.out_z          = out_ch.out_z;
        got.tex_u          = out_ch.tex_u;
        got.tex_v          = out_ch.tex_v;
        got.out_color      = out_ch.out_color;
        got.element_number = out_ch.element_number;
        got.last           = out_ch.last;
        board.check_record(got);
      end
    end
  end

  initial begin : result_sink
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        sink_hold--;
        out_ch.ready <= 1'b0;
      end else begin
        if (stall == 0 && !sink_steady) stall = pick_idle();
        if (stall > 0) begin
          stall--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    logic [FSEL_W-1:0] phase_font [5];
    board = new();
    phase_font = '{2'd3, 2'd1, 2'd0, 2'd2, 2'd3};
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.opcode        <= OP_START;
    in_ch.pen_x         <= '0;
    in_ch.pen_y         <= '0;
    in_ch.depth_z       <= '0;
    in_ch.draw_color    <= '0;
    in_ch.scale         <= '0;
    in_ch.base_vertex   <= '0;
    in_ch.code_or_slot  <= '0;
    in_ch.glyph_box     <= '0;
    in_ch.glyph_advance <= '0;
    in_ch.glyph_uv      <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.font_select  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    write_font(2'd0);
    run_directed();
    for (int p = 0; p < 5; p++) begin
      settle_block();
      write_font(phase_font[p]);
      if (p == 0) begin
        // stall the results for a long stretch while words keep coming
        src_steady  = 1'b1;
        sink_steady = 1'b0;
        sink_hold   = 300;
      end else begin
        src_steady  = ($urandom_range(0, 3) == 0);
        sink_steady = ($urandom_range(0, 3) == 0);
      end
      run_random(PHASE_WORDS);
    end
    src_steady  = 1'b0;
    sink_steady = 1'b0;
    settle_block();
    if (board.expected_records.size() != 0) begin
      $error("%0d expected records never arrived", board.expected_records.size());
      board.mismatches++;
    end
    if (board.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
